// ===== hdl/ols_pkg.sv =====
// shared types and codes for the ordered list store
`timescale 1ns / 1ps
package ols_pkg;

   localparam int VALUE_W = 32;

   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_INSERT     = 3'd2;
   localparam logic [2:0] REQ_SEARCH     = 3'd3;
   localparam logic [2:0] REQ_MODIFY     = 3'd4;
   localparam logic [2:0] REQ_DELETE     = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_POS   = 3'd4;

   localparam logic [2:0] CELL_HOLD    = 3'd0;
   localparam logic [2:0] CELL_COMPARE = 3'd1;
   localparam logic [2:0] CELL_INSERT  = 3'd2;
   localparam logic [2:0] CELL_MODIFY  = 3'd3;
   localparam logic [2:0] CELL_DELETE  = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic [VALUE_W-1:0] data;
   } cell_ctrl_type;

endpackage

// ===== hdl/ols_cell.sv =====
// one list position: holds an entry, compares it and shifts with its neighbors
`timescale 1ns / 1ps
module ols_cell
   import ols_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int INDEX    = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [CNT_W-1:0]   count,
   input  logic [CNT_W-1:0]   ins_pos,
   input  logic [VALUE_W-1:0] left_value,
   input  logic [VALUE_W-1:0] right_value,
   input  logic               seen_in,
   output logic               seen_out,
   output logic [VALUE_W-1:0] value_out
);

   localparam logic [CNT_W-1:0] K_IDX = CNT_W'(INDEX);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               hit_ff, hit_in;

   assign seen_out  = seen_in | hit_ff;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      hit_in   = hit_ff;
      unique case (ctrl.op)
         CELL_COMPARE: begin
            hit_in = (K_IDX < count) && (value_ff == ctrl.data);
         end
         CELL_INSERT: begin
            if (K_IDX > ins_pos) begin
               value_in = left_value;
            end else if (K_IDX == ins_pos) begin
               value_in = ctrl.data;
            end
         end
         CELL_MODIFY: begin
            if (hit_ff && !seen_in) begin
               value_in = ctrl.data;
            end
         end
         CELL_DELETE: begin
            if (seen_out) begin
               value_in = right_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== hdl/ordered_list_store_unit.sv =====
// ordered list store: request sequencer over a row of list cells
// result: registered in S_FIN after the S_CMP and S_APL passes, held there while an earlier response waits
// requests: taken only in S_IDLE, one at a time (compare, apply, result, accept)
// the compare pass and the shift/write pass each act on the whole cell row at once
// reset: synchronous, empties the list and drops any pending result
`timescale 1ns / 1ps
module ordered_list_store_unit
   import ols_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // item_value[31:0], replacement[63:32], position[67:64], zero[71:68]
   input  logic [71:0] req_tdata,
   // req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], found[3], length[8:4], first_value[40:9], last_value[72:41], zero[79:73]
   output logic [79:0] rsp_tdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_APL  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [2:0]         kind_ff;
   logic [VALUE_W-1:0] value_ff, repl_ff;
   logic [3:0]         pos_ff;
   logic [2:0]         status_ff, status_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   cell_ctrl_type      ctrl;
   logic [CNT_W-1:0]   ins_pos;
   logic [CNT_W-1:0]   pos_ext;
   logic               pos_bad;
   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY:0]  seen;
   logic [IDX_W-1:0]   last_idx;
   logic [VALUE_W-1:0] first_val, last_val;
   logic [4:0]         length;
   logic               req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign seen[0]    = 1'b0;
   assign pos_ext    = CNT_W'(pos_ff);
   assign pos_bad    = ({{CNT_W{1'b0}}, pos_ff} >= {4'b0, count_ff});

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [VALUE_W-1:0] left_v, right_v;
      if (k == 0) begin : g_first
         assign left_v = ctrl.data;
      end else begin : g_mid
         assign left_v = cell_value[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[k];
      end else begin : g_inner
         assign right_v = cell_value[k+1];
      end
      ols_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .count       (count_ff),
         .ins_pos     (ins_pos),
         .left_value  (left_v),
         .right_value (right_v),
         .seen_in     (seen[k]),
         .seen_out    (seen[k+1]),
         .value_out   (cell_value[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.data    = value_ff;
      ins_pos      = '0;
      last_idx     = IDX_W'(count_ff - 1'b1);
      first_val    = (count_ff != '0) ? cell_value[0] : '0;
      last_val     = (count_ff != '0) ? cell_value[last_idx] : '0;
      length       = 5'(count_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctrl.op  = CELL_COMPARE;
            state_in = S_APL;
         end
         S_APL: begin
            status_in = ST_OK;
            found_in  = 1'b0;
            state_in  = S_FIN;
            case (kind_ff)
               REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
                  if (count_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                  end else if (kind_ff == REQ_INSERT && pos_bad) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     ctrl.op  = CELL_INSERT;
                     ins_pos  = (kind_ff == REQ_PUSH_FRONT) ? '0 :
                                (kind_ff == REQ_PUSH_BACK) ? count_ff : pos_ext;
                     count_in = CNT_W'(count_ff + 1'b1);
                  end
               end
               REQ_SEARCH, REQ_MODIFY, REQ_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (!seen[CAPACITY]) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     found_in = 1'b1;
                     if (kind_ff == REQ_MODIFY) begin
                        ctrl.op   = CELL_MODIFY;
                        ctrl.data = repl_ff;
                     end else if (kind_ff == REQ_DELETE) begin
                        ctrl.op  = CELL_DELETE;
                        count_in = CNT_W'(count_ff - 1'b1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, last_val, first_val, length, found_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         kind_ff  <= req_tuser;
         value_ff <= req_tdata[31:0];
         repl_ff  <= req_tdata[63:32];
         pos_ff   <= req_tdata[67:64];
      end
   end

endmodule

// ===== sim/tb_ordered_list_store_unit.sv =====
`timescale 1ns / 1ps
// testbench for the ordered list store: directed and random list requests against a shadow list
module tb_ordered_list_store_unit;
   import ols_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int PHASE_ITEMS = 375;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;

   // request codes the block answers without changing the list
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]         status;
      logic               found;
      logic [4:0]         length;
      logic [VALUE_W-1:0] first_value;
      logic [VALUE_W-1:0] last_value;
   } list_rsp_type;

   class list_shadow;
      logic [VALUE_W-1:0] entries [CAPACITY];
      int                 count;
      list_rsp_type       rsp_q [$];
      int unsigned        mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function int size();
         return count;
      endfunction

      function logic [VALUE_W-1:0] entry_at(int idx);
         return entries[idx];
      endfunction

      function int pending();
         return rsp_q.size();
      endfunction

      function void insert_entry(int idx, logic [VALUE_W-1:0] value);
         int k;
         for (k = count; k > idx; k--) entries[k] = entries[k-1];
         entries[idx] = value;
         count++;
      endfunction

      // update the shadow list for one accepted request transaction
      function void apply_request(logic [2:0] kind, logic [VALUE_W-1:0] value,
                                  logic [VALUE_W-1:0] repl, logic [3:0] pos);
         list_rsp_type r;
         int           idx;
         int           k;
         r.status = ST_OK;
         r.found  = 1'b0;
         case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
               if (count >= CAPACITY) r.status = ST_FULL;
               else if (kind == REQ_PUSH_FRONT) insert_entry(0, value);
               else if (kind == REQ_PUSH_BACK) insert_entry(count, value);
               else if (int'(pos) < count) insert_entry(int'(pos), value);
               else r.status = ST_BAD_POS;
            end
            REQ_SEARCH, REQ_MODIFY, REQ_DELETE: begin
               if (count == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  idx = count;
                  for (k = count - 1; k >= 0; k--) if (entries[k] == value) idx = k;
                  if (idx >= count) begin
                     r.status = ST_NOT_FOUND;
                  end else begin
                     r.found = 1'b1;
                     if (kind == REQ_MODIFY) begin
                        entries[idx] = repl;
                     end else if (kind == REQ_DELETE) begin
                        for (k = idx; k + 1 < count; k++) entries[k] = entries[k+1];
                        count--;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.length      = count[4:0];
         r.first_value = (count != 0) ? entries[0] : '0;
         r.last_value  = (count != 0) ? entries[count-1] : '0;
         rsp_q.push_back(r);
      endfunction

      function void compare_response(logic [79:0] d);
         list_rsp_type act;
         list_rsp_type exp;
         act.status      = d[2:0];
         act.found       = d[3];
         act.length      = d[8:4];
         act.first_value = d[40:9];
         act.last_value  = d[72:41];
         if (rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d found %0d length %0d first %h last %h",
                        act.status, act.found, act.length, act.first_value, act.last_value);
            return;
         end
         exp = rsp_q.pop_front();
         if (act.status !== exp.status || act.found !== exp.found ||
             act.length !== exp.length || act.first_value !== exp.first_value ||
             act.last_value !== exp.last_value) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected status %0d found %0d length %0d first %h last %h",
                        exp.status, exp.found, exp.length, exp.first_value, exp.last_value);
               $display("          got      status %0d found %0d length %0d first %h last %h",
                        act.status, act.found, act.length, act.first_value, act.last_value);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   list_shadow sb = new();
   int         idle_pct       = 0;
   int         stall_pct      = 0;
   int         accepted_items = 0;

   ordered_list_store_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.apply_request(req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[67:64]);
         if (rsp_tvalid && rsp_tready)
            sb.compare_response(rsp_tdata);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL ordered_list_store_unit");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_request(input logic [2:0] kind, input logic [VALUE_W-1:0] value,
                               input logic [VALUE_W-1:0] repl, input logic [3:0] pos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, pos, repl, value};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      @(negedge clock);
      if (kind <= REQ_DELETE) accepted_items++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0) return $urandom;
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 7);
         1:       return 32'h8000_0000 | $urandom_range(0, 3);
         2:       return 32'h7fff_fffc | $urandom_range(0, 3);
         default: return 32'hffff_fff8 | $urandom_range(0, 7);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_key();
      if (sb.size() > 0 && $urandom_range(0, 99) < 70)
         return sb.entry_at($urandom_range(0, sb.size() - 1));
      return pick_value();
   endfunction

   function automatic logic [3:0] pick_position();
      if (sb.size() > 0 && $urandom_range(0, 99) < 80)
         return 4'($urandom_range(0, sb.size() - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [2:0] pick_insert_kind();
      case ($urandom_range(0, 2))
         0:       return REQ_PUSH_FRONT;
         1:       return REQ_PUSH_BACK;
         default: return REQ_INSERT;
      endcase
   endfunction

   function automatic logic [2:0] pick_lookup_kind();
      case ($urandom_range(0, 2))
         0:       return REQ_SEARCH;
         1:       return REQ_MODIFY;
         default: return REQ_DELETE;
      endcase
   endfunction

   task automatic send_mixed();
      int         r;
      logic [2:0] kind;
      r = $urandom_range(0, 99);
      if (r < 45) kind = pick_insert_kind();
      else if (r < 93) kind = pick_lookup_kind();
      else kind = r[0] ? REQ_SPARE_7 : REQ_SPARE_6;
      send_request(kind, (kind <= REQ_INSERT) ? pick_value() : pick_key(), pick_value(),
                   pick_position());
   endtask

   // grow the list to capacity, then push against the full list
   task automatic send_fill();
      while (sb.size() < CAPACITY)
         send_request(pick_insert_kind(), pick_value(), $urandom, pick_position());
      repeat ($urandom_range(1, 2))
         send_request(pick_insert_kind(), pick_value(), $urandom, pick_position());
   endtask

   // shrink the list to empty, then hit the empty list once
   task automatic send_drain();
      while (sb.size() > 0) begin
         if ($urandom_range(0, 99) < 80)
            send_request(REQ_DELETE, pick_key(), $urandom, 4'($urandom_range(0, 15)));
         else
            send_request(pick_lookup_kind(), pick_key(), pick_value(),
                         4'($urandom_range(0, 15)));
      end
      send_request(pick_lookup_kind(), pick_value(), pick_value(), 4'($urandom_range(0, 15)));
   endtask

   task automatic run_phase(input int idle, input int stall);
      int target;
      target    = accepted_items + PHASE_ITEMS;
      idle_pct  = idle;
      stall_pct = stall;
      while (accepted_items < target) begin
         case ($urandom_range(0, 9))
            0, 1: send_fill();
            2, 3: send_drain();
            9: begin
               repeat (4)
                  send_request(3'($urandom_range(0, 7)), $urandom, $urandom,
                               4'($urandom_range(0, 15)));
            end
            default: repeat (8) send_mixed();
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list cases
      send_request(REQ_SEARCH, 32'h0, 32'h0, 4'd0);
      send_request(REQ_MODIFY, 32'h0, 32'hffff_ffff, 4'd0);
      send_request(REQ_DELETE, 32'h0, 32'h0, 4'd0);
      send_request(REQ_INSERT, 32'h5, 32'h0, 4'd0);
      send_request(REQ_SPARE_6, 32'h5, 32'h0, 4'd0);
      // deleting the only entry
      send_request(REQ_PUSH_FRONT, 32'h8000_0000, 32'h0, 4'd0);
      send_request(REQ_DELETE, 32'h8000_0000, 32'h0, 4'd0);
      // index inserts, front and bad positions
      send_request(REQ_PUSH_BACK, 32'h7fff_ffff, 32'h0, 4'd0);
      send_request(REQ_INSERT, 32'hffff_ffff, 32'h0, 4'd0);
      send_request(REQ_INSERT, 32'h1, 32'h0, 4'd1);
      send_request(REQ_INSERT, 32'h2, 32'h0, 4'd3);
      send_request(REQ_INSERT, 32'h2, 32'h0, 4'd15);
      // lookups
      send_request(REQ_SEARCH, 32'h1, 32'h0, 4'd0);
      send_request(REQ_SEARCH, 32'h2, 32'h0, 4'd0);
      send_request(REQ_MODIFY, 32'h7fff_ffff, 32'h8000_0000, 4'd0);
      send_request(REQ_SPARE_7, 32'h1, 32'h0, 4'd0);
      // full list
      while (sb.size() < CAPACITY)
         send_request(REQ_PUSH_BACK, (sb.size() % 2 != 0) ? 32'h7fff_ffff : 32'h8000_0000,
                      32'h0, 4'd0);
      send_request(REQ_PUSH_FRONT, 32'h3, 32'h0, 4'd0);
      send_request(REQ_INSERT, 32'h3, 32'h0, 4'd0);
      send_request(REQ_DELETE, 32'hffff_ffff, 32'h0, 4'd0);

      run_phase(0, 0);
      run_phase(66, 0);
      run_phase(0, 66);
      run_phase(7, 7);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("PASS ordered_list_store_unit");
      end else begin
         $display("FAIL ordered_list_store_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ols_pkg.sv
hdl/ols_cell.sv
hdl/ordered_list_store_unit.sv
sim/tb_ordered_list_store_unit.sv
